// ----- hdl/lgs_pkg.sv -----
// shared types, constants and codes of the life grid generation step block
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;

    // row and column index widths inside the grid store
    localparam int RA_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CA_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    // widths that hold a clamped size, 1 up to the maximum
    localparam int SZR_W = $clog2(MAX_ROWS + 1);
    localparam int SZC_W = $clog2(MAX_COLUMNS + 1);

    // item field and configuration widths
    localparam int ACT_W     = 2;
    localparam int FLD_ROW_W = 6;
    localparam int FLD_COL_W = 6;
    localparam int CFG_W     = 7;
    localparam int CIDX_W    = 2;

    localparam logic [CIDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_WRAP_EDGES  = 2'd2;

    localparam logic [CFG_W-1:0] CFG_SIZE_RST = 7'd64;

    // B3/S23 neighbor counts
    localparam logic [3:0] NBR_BIRTH = 4'd3;
    localparam logic [3:0] NBR_KEEP  = 4'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_STEP  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        RD_CELL,
        RD_LAST,
        RD_FIRST,
        RD_NEXT
    } t_rd_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CELL_RD,
        ST_CELL_APPLY,
        ST_GEN_LAST,
        ST_GEN_FIRST,
        ST_GEN_ROW0,
        ST_GEN_FETCH,
        ST_GEN_NEXT,
        ST_GEN_CALC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic    take_in;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_cell;
        logic    wr_gen;
        logic    cap_res;
        logic    ld_up;
        logic    ld_mid0;
        logic    ld_dn;
        logic    row_clr;
        logic    row_inc;
        logic    out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic last_row;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- hdl/life_grid_generation_step_top.sv -----
// top level of the life grid generation step block
`timescale 1ns / 1ps
`default_nettype none

// Grid of MAX_ROWS by MAX_COLUMNS one-bit cells, all dead after reset, held as one
// row of the grid per word of a two-port ram, with a valid flag per row so no
// clearing pass is needed. Each item writes a cell, reads a cell, or advances the
// active area one generation under the B3/S23 rule, and gives exactly one result
// item. A write or a read goes through accept, row read, apply and result load;
// the unused action goes through accept and result load. A generation reads the
// last row and the first row, loads row 0, then sweeps the rows one by one on the
// single ram read port (fetch the row below, load it, compute all columns in
// parallel and write the row back), and ends with the result load. One item is in
// work at a time; the next item is accepted once the previous one has moved into
// the output register, even if that result is still waiting to be taken.
// Configuration is to be written only while idle; the block does not enforce this.
module life_grid_generation_step_top
    import lgs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CIDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [ACT_W-1:0]     i_action,
    input  wire logic [FLD_ROW_W-1:0] i_row,
    input  wire logic [FLD_COL_W-1:0] i_column,
    input  wire logic                 i_alive_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_alive_out,
    output logic [ACT_W-1:0]          o_done_action
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    lgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_out_ready(i_out_ready),
        .i_stat     (dp_stat),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .o_cmd      (dp_cmd)
    );

    lgs_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_action),
        .i_row        (i_row),
        .i_column     (i_column),
        .i_alive_in   (i_alive_in),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .o_alive_out  (o_alive_out),
        .o_done_action(o_done_action)
    );

endmodule

`default_nettype wire

// ----- hdl/lgs_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module lgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                          i_wr_data,
    input  wire logic                                      i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/lgs_datapath.sv -----
// grid row store, row window registers, neighbor lanes and result register
`timescale 1ns / 1ps
`default_nettype none

module lgs_datapath
    import lgs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CIDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic [ACT_W-1:0]     i_action,
    input  wire logic [FLD_ROW_W-1:0] i_row,
    input  wire logic [FLD_COL_W-1:0] i_column,
    input  wire logic                 i_alive_in,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    output logic                      o_alive_out,
    output logic [ACT_W-1:0]          o_done_action
);

    logic [CFG_W-1:0]       r_grid_width;
    logic [CFG_W-1:0]       r_grid_height;
    logic                   r_wrap_edges;

    logic [ACT_W-1:0]       r_act;
    logic [FLD_ROW_W-1:0]   r_row;
    logic [FLD_COL_W-1:0]   r_col;
    logic                   r_alive;
    logic                   r_res_bit;

    logic [MAX_ROWS-1:0]    r_vld;
    logic                   r_rd_vld;
    logic [RA_W-1:0]        r_row_cnt;

    logic [MAX_COLUMNS-1:0] r_up;
    logic [MAX_COLUMNS-1:0] r_mid;
    logic [MAX_COLUMNS-1:0] r_dn;
    logic [MAX_COLUMNS-1:0] r_row0;

    logic [SZR_W-1:0]       h_clamp;
    logic [SZC_W-1:0]       w_clamp;
    logic [RA_W-1:0]        h_m1;
    logic [CA_W-1:0]        w_m1;
    logic [RA_W-1:0]        row_idx;
    logic [CA_W-1:0]        col_idx;
    logic                   in_area;

    logic                   rd_en;
    logic [RA_W-1:0]        rd_addr;
    logic [MAX_COLUMNS-1:0] rd_data;
    logic [MAX_COLUMNS-1:0] rd_eff;
    logic                   wr_en;
    logic [RA_W-1:0]        wr_addr;
    logic [MAX_COLUMNS-1:0] wr_data;

    logic [MAX_COLUMNS-1:0] col_mask;
    logic [MAX_COLUMNS-1:0] up_m;
    logic [MAX_COLUMNS-1:0] mid_m;
    logic [MAX_COLUMNS-1:0] dn_m;
    logic [MAX_COLUMNS-1:0] up_l;
    logic [MAX_COLUMNS-1:0] up_r;
    logic [MAX_COLUMNS-1:0] mid_l;
    logic [MAX_COLUMNS-1:0] mid_r;
    logic [MAX_COLUMNS-1:0] dn_l;
    logic [MAX_COLUMNS-1:0] dn_r;
    logic [MAX_COLUMNS-1:0] life;
    logic [MAX_COLUMNS-1:0] gen_row;
    logic [MAX_COLUMNS-1:0] cell_row;

    function automatic logic [SZR_W-1:0] clamp_rows(logic [CFG_W-1:0] v);
        logic [SZR_W-1:0] res;
        if (v == '0) begin
            res = SZR_W'(1);
        end else if (32'(v) > MAX_ROWS) begin
            res = SZR_W'(MAX_ROWS);
        end else begin
            res = SZR_W'(v);
        end
        return res;
    endfunction

    function automatic logic [SZC_W-1:0] clamp_cols(logic [CFG_W-1:0] v);
        logic [SZC_W-1:0] res;
        if (v == '0) begin
            res = SZC_W'(1);
        end else if (32'(v) > MAX_COLUMNS) begin
            res = SZC_W'(MAX_COLUMNS);
        end else begin
            res = SZC_W'(v);
        end
        return res;
    endfunction

    // each lane sees its left neighbor; with wrap set, lane 0 wraps to the last active column
    function automatic logic [MAX_COLUMNS-1:0] left_of(logic [MAX_COLUMNS-1:0] v,
                                                       logic wrap, logic [CA_W-1:0] last);
        logic [MAX_COLUMNS-1:0] res;
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            if (c == 0) begin
                res[c] = wrap ? v[last] : 1'b0;
            end else begin
                res[c] = v[c-1];
            end
        end
        return res;
    endfunction

    // right neighbor; with wrap set, the last active lane wraps to column 0
    function automatic logic [MAX_COLUMNS-1:0] right_of(logic [MAX_COLUMNS-1:0] v,
                                                        logic wrap, logic [CA_W-1:0] last);
        logic [MAX_COLUMNS-1:0] res;
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            if (wrap && (CA_W'(c) == last)) begin
                res[c] = v[0];
            end else if (c == MAX_COLUMNS - 1) begin
                res[c] = 1'b0;
            end else begin
                res[c] = v[c+1];
            end
        end
        return res;
    endfunction

    assign h_clamp = clamp_rows(r_grid_height);
    assign w_clamp = clamp_cols(r_grid_width);
    assign h_m1    = RA_W'(h_clamp - SZR_W'(1));
    assign w_m1    = CA_W'(w_clamp - SZC_W'(1));
    assign row_idx = RA_W'(r_row);
    assign col_idx = CA_W'(r_col);
    assign in_area = (32'(r_row) < 32'(h_clamp)) && (32'(r_col) < 32'(w_clamp));

    assign o_stat.last_row = (r_row_cnt == h_m1);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= CFG_SIZE_RST;
            r_grid_height <= CFG_SIZE_RST;
            r_wrap_edges  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                CFG_WRAP_EDGES:  r_wrap_edges  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // item fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_act   <= i_action;
            r_row   <= i_row;
            r_col   <= i_column;
            r_alive <= i_alive_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_res_bit <= 1'b0;
        end else if (i_cmd.cap_res && (r_act == ACT_READ)) begin
            r_res_bit <= in_area ? rd_eff[col_idx] : 1'b0;
        end
    end

    // grid store access
    always_comb begin
        case (i_cmd.rd_sel)
            RD_CELL:  rd_addr = row_idx;
            RD_LAST:  rd_addr = h_m1;
            RD_FIRST: rd_addr = '0;
            RD_NEXT:  rd_addr = r_row_cnt + RA_W'(1);
            default:  rd_addr = '0;
        endcase
    end

    assign rd_en = i_cmd.rd_en;

    always_comb begin
        cell_row          = rd_eff;
        cell_row[col_idx] = r_alive;
    end

    assign wr_en   = (i_cmd.wr_cell && (r_act == ACT_WRITE) && in_area) || i_cmd.wr_gen;
    assign wr_addr = i_cmd.wr_gen ? r_row_cnt : row_idx;
    assign wr_data = i_cmd.wr_gen ? gen_row : cell_row;

    lgs_ram #(
        .WIDTH(MAX_COLUMNS),
        .DEPTH(MAX_ROWS)
    ) u_grid (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // rows never written read as dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_vld <= r_vld[rd_addr];
        end
    end

    assign rd_eff = r_rd_vld ? rd_data : '0;

    // row window for the generation sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_clr) begin
            r_row_cnt <= '0;
        end else if (i_cmd.row_inc) begin
            r_row_cnt <= r_row_cnt + RA_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_up) begin
            r_up <= r_wrap_edges ? rd_eff : '0;
        end else if (i_cmd.row_inc) begin
            r_up <= r_mid;
        end
        if (i_cmd.ld_mid0) begin
            r_mid  <= rd_eff;
            r_row0 <= rd_eff;
        end else if (i_cmd.row_inc) begin
            r_mid <= r_dn;
        end
        if (i_cmd.ld_dn) begin
            if (o_stat.last_row) begin
                r_dn <= r_wrap_edges ? r_row0 : '0;
            end else begin
                r_dn <= rd_eff;
            end
        end
    end

    // one lane per column: count the eight neighbors and apply the rule
    always_comb begin
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            col_mask[c] = (32'(c) < 32'(w_clamp));
        end
    end

    assign up_m  = r_up & col_mask;
    assign mid_m = r_mid & col_mask;
    assign dn_m  = r_dn & col_mask;
    assign up_l  = left_of(up_m, r_wrap_edges, w_m1);
    assign up_r  = right_of(up_m, r_wrap_edges, w_m1);
    assign mid_l = left_of(mid_m, r_wrap_edges, w_m1);
    assign mid_r = right_of(mid_m, r_wrap_edges, w_m1);
    assign dn_l  = left_of(dn_m, r_wrap_edges, w_m1);
    assign dn_r  = right_of(dn_m, r_wrap_edges, w_m1);

    always_comb begin
        logic [3:0] n;
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            n = 4'(up_l[c]) + 4'(up_m[c]) + 4'(up_r[c]) + 4'(mid_l[c]) + 4'(mid_r[c])
                + 4'(dn_l[c]) + 4'(dn_m[c]) + 4'(dn_r[c]);
            life[c] = (n == NBR_BIRTH) || (r_mid[c] && (n == NBR_KEEP));
        end
    end

    // columns outside the active area keep their old contents
    assign gen_row = (life & col_mask) | (r_mid & ~col_mask);

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            o_alive_out   <= r_res_bit;
            o_done_action <= r_act;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/lgs_ctrl.sv -----
// sequencer for cell access and the row by row generation sweep
`timescale 1ns / 1ps
`default_nettype none

module lgs_ctrl
    import lgs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [ACT_W-1:0] i_action,
    input  wire logic             i_out_ready,
    input  wire t_dp_stat         i_stat,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output t_dp_cmd               o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_action)
                        ACT_WRITE, ACT_READ: n_state = ST_CELL_RD;
                        ACT_STEP:            n_state = ST_GEN_LAST;
                        default:             n_state = ST_DONE;
                    endcase
                end
            end
            ST_CELL_RD:    n_state = ST_CELL_APPLY;
            ST_CELL_APPLY: n_state = ST_DONE;
            ST_GEN_LAST:   n_state = ST_GEN_FIRST;
            ST_GEN_FIRST:  n_state = ST_GEN_ROW0;
            ST_GEN_ROW0:   n_state = ST_GEN_FETCH;
            ST_GEN_FETCH:  n_state = ST_GEN_NEXT;
            ST_GEN_NEXT:   n_state = ST_GEN_CALC;
            ST_GEN_CALC:   n_state = i_stat.last_row ? ST_DONE : ST_GEN_FETCH;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.rd_sel = RD_CELL;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.take_in = i_in_valid;
            end
            ST_CELL_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_CELL;
            end
            ST_CELL_APPLY: begin
                o_cmd.wr_cell = 1'b1;
                o_cmd.cap_res = 1'b1;
            end
            ST_GEN_LAST: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_LAST;
            end
            ST_GEN_FIRST: begin
                o_cmd.ld_up   = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RD_FIRST;
                o_cmd.row_clr = 1'b1;
            end
            ST_GEN_ROW0: begin
                o_cmd.ld_mid0 = 1'b1;
            end
            ST_GEN_FETCH: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_NEXT;
            end
            ST_GEN_NEXT: begin
                o_cmd.ld_dn = 1'b1;
            end
            ST_GEN_CALC: begin
                o_cmd.wr_gen  = 1'b1;
                o_cmd.row_inc = 1'b1;
            end
            ST_DONE: begin
                o_cmd.out_ld = out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (o_cmd.out_ld) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- hdl/lgs_checker.sv -----
// port level checks of the life grid generation step block and their bind
`timescale 1ns / 1ps
`default_nettype none

module lgs_checker
    import lgs_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire logic             o_alive_out,
    input wire logic [ACT_W-1:0] o_done_action
);

    // a waiting result item stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_alive_out) && $stable(o_done_action))
        else $error("result item changed while waiting");

    // only a read reports a live cell
    a_alive_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_done_action != ACT_READ) |-> !o_alive_out)
        else $error("alive_out set on an item that is not a read");

    // one item in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item accepted while one is in work");

endmodule

bind life_grid_generation_step_top lgs_checker u_lgs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_alive_out  (o_alive_out),
    .o_done_action(o_done_action)
);

`default_nettype wire
